>>> design/utf8tc_pkg.sv
// Shared types, constants and codes of the UTF-8 text cursor engine.
// Used by every module but the queue; depends on nothing else.
package utf8tc_pkg;

  localparam int MAX_COLS    = 256;
  localparam int MAX_ROWS    = 128;
  localparam int SCROLL_STEP = 8;
  localparam int TAB_SPACES  = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam int BYTE_W    = 8;
  localparam int ROW_W     = 7;
  localparam int COL_W     = 8;
  localparam int CUR_COL_W = 9;
  localparam int CP_W      = 21;
  localparam int COLOR_W   = 24;
  localparam int CNT_W     = 8;
  localparam int TCOL_W    = 9;
  localparam int TROW_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int TAB_CNT_W = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;

  localparam logic [TCOL_W-1:0]  COLUMNS_RESET = TCOL_W'(80);
  localparam logic [TROW_W-1:0]  ROWS_RESET    = TROW_W'(25);
  localparam logic [COLOR_W-1:0] COLOR_RESET   = 24'hD8E0F0;

  localparam logic [BYTE_W-1:0] BYTE_NEWLINE   = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_RETURN    = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_TAB       = 8'h09;
  localparam logic [BYTE_W-1:0] BYTE_BACKSPACE = 8'h08;
  localparam logic [BYTE_W-1:0] LEAD4_MIN      = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_MIN      = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_MIN      = 8'hC0;
  localparam logic [CP_W-1:0]   SPACE_CP       = CP_W'(32);

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_RETURN,
    OP_TAB,
    OP_BACKSPACE
  } op_e;

  typedef enum logic {
    KIND_CELL   = 1'b0,
    KIND_SCROLL = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_COLUMNS = 2'd0,
    CFG_TEXT_ROWS    = 2'd1,
    CFG_FORE_COLOR   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    op_e             op;
    logic [CP_W-1:0] cp;
  } op_t;

  typedef struct packed {
    kind_e              kind;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [CP_W-1:0]    cp;
    logic [COLOR_W-1:0] color;
    logic [CNT_W-1:0]   cnt;
    logic               last;
  } res_t;

  // Effective screen size, already saturated to the grid limits, and ink color.
  typedef struct packed {
    logic [TCOL_W-1:0]  cols;
    logic [TROW_W-1:0]  rows;
    logic [COLOR_W-1:0] color;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [CUR_COL_W-1:0] col;
  } stat_t;

endpackage

>>> design/utf8tc_fifo.sv
// Small synchronous queue of packed words, used between the stages.
// Depends on no package.
module utf8tc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

>>> design/utf8tc_front.sv
// Front end: UTF-8 decoding and classification of each accepted byte.
// Depends on utf8tc_pkg for widths, byte codes and the operation type.
module utf8tc_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [utf8tc_pkg::BYTE_W-1:0]    in_byte_i,
  output logic                             op_valid_o,
  output utf8tc_pkg::op_t                  op_o
);

  logic [utf8tc_pkg::CP_W-1:0] partial_q, partial_d;
  logic [1:0]                  pending_q, pending_d;
  logic [utf8tc_pkg::CP_W-1:0] joined;
  logic                        is_cont;

  assign is_cont = (in_byte_i[7:6] == 2'b10);
  assign joined  = {partial_q[utf8tc_pkg::CP_W-7:0], in_byte_i[5:0]};

  always_comb begin
    partial_d  = partial_q;
    pending_d  = pending_q;
    op_valid_o = 1'b0;
    op_o.op    = utf8tc_pkg::OP_PUT;
    op_o.cp    = '0;
    if (accept_i) begin
      if ((pending_q != 2'd0) && is_cont) begin
        partial_d = joined;
        pending_d = pending_q - 2'd1;
        if (pending_q == 2'd1) begin
          op_valid_o = 1'b1;
          op_o.cp    = joined;
        end
      end else begin
        // A broken sequence is dropped and this byte starts over.
        pending_d = 2'd0;
        if (in_byte_i >= utf8tc_pkg::LEAD4_MIN) begin
          partial_d = utf8tc_pkg::CP_W'(in_byte_i[2:0]);
          pending_d = 2'd3;
        end else if (in_byte_i >= utf8tc_pkg::LEAD3_MIN) begin
          partial_d = utf8tc_pkg::CP_W'(in_byte_i[3:0]);
          pending_d = 2'd2;
        end else if (in_byte_i >= utf8tc_pkg::LEAD2_MIN) begin
          partial_d = utf8tc_pkg::CP_W'(in_byte_i[4:0]);
          pending_d = 2'd1;
        end else begin
          op_valid_o = 1'b1;
          op_o.cp    = utf8tc_pkg::CP_W'(in_byte_i);
          case (in_byte_i)
            utf8tc_pkg::BYTE_NEWLINE:   op_o.op = utf8tc_pkg::OP_NEWLINE;
            utf8tc_pkg::BYTE_RETURN:    op_o.op = utf8tc_pkg::OP_RETURN;
            utf8tc_pkg::BYTE_TAB:       op_o.op = utf8tc_pkg::OP_TAB;
            utf8tc_pkg::BYTE_BACKSPACE: op_o.op = utf8tc_pkg::OP_BACKSPACE;
            default:                    op_o.op = utf8tc_pkg::OP_PUT;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      pending_q <= 2'd0;
    end else begin
      partial_q <= partial_d;
      pending_q <= pending_d;
    end
  end

endmodule

>>> design/utf8tc_back.sv
// Back end: cursor sequencer that carries out one queued operation and
// emits at most one result per cycle. Depends on utf8tc_pkg.
module utf8tc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  utf8tc_pkg::cfg_t cfg_i,
  input  logic             op_valid_i,
  input  utf8tc_pkg::op_t  op_i,
  output logic             op_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output utf8tc_pkg::res_t res_o,
  output utf8tc_pkg::stat_t stat_o
);

  localparam int ROW_W = utf8tc_pkg::ROW_W;
  localparam int CCW   = utf8tc_pkg::CUR_COL_W;
  localparam int TCW   = utf8tc_pkg::TAB_CNT_W;

  logic [ROW_W-1:0] row_q, row_d;
  logic [CCW-1:0]   col_q, col_d;
  logic [TCW-1:0]   step_q, step_d;

  logic                          advance;
  logic [ROW_W:0]                nl_row;
  logic                          scroll_hit;
  logic [ROW_W-1:0]              row_scrolled, nl_row_next;
  logic [utf8tc_pkg::CNT_W-1:0]  lines;
  logic                          wrap;
  logic [ROW_W-1:0]              wr_row;
  logic [CCW-1:0]                wr_col;
  logic                          put_done;

  assign advance      = op_valid_i && !res_full_i;
  assign nl_row       = {1'b0, row_q} + (ROW_W + 1)'(1);
  assign scroll_hit   = (nl_row >= cfg_i.rows);
  assign row_scrolled = (nl_row >= (ROW_W + 1)'(utf8tc_pkg::SCROLL_STEP)) ?
                        ROW_W'(nl_row - (ROW_W + 1)'(utf8tc_pkg::SCROLL_STEP)) : '0;
  assign nl_row_next  = scroll_hit ? row_scrolled : nl_row[ROW_W-1:0];
  assign lines        = (cfg_i.rows < utf8tc_pkg::CNT_W'(utf8tc_pkg::SCROLL_STEP)) ?
                        cfg_i.rows : utf8tc_pkg::CNT_W'(utf8tc_pkg::SCROLL_STEP);
  assign wrap         = (col_q >= cfg_i.cols);
  assign wr_row       = wrap ? nl_row[ROW_W-1:0] : row_q;
  assign wr_col       = wrap ? '0 : col_q;
  assign put_done     = (op_i.op == utf8tc_pkg::OP_PUT) ||
                        (step_q == TCW'(utf8tc_pkg::TAB_SPACES - 1));
  assign stat_o.row   = row_q;
  assign stat_o.col   = col_q;

  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    step_d      = step_q;
    op_pop_o    = 1'b0;
    res_push_o  = 1'b0;
    res_o.kind  = utf8tc_pkg::KIND_CELL;
    res_o.row   = '0;
    res_o.col   = '0;
    res_o.cp    = '0;
    res_o.color = '0;
    res_o.cnt   = '0;
    res_o.last  = 1'b0;
    if (advance) begin
      case (op_i.op)
        utf8tc_pkg::OP_NEWLINE: begin
          op_pop_o = 1'b1;
          col_d    = '0;
          row_d    = nl_row_next;
          if (scroll_hit) begin
            res_push_o = 1'b1;
            res_o.kind = utf8tc_pkg::KIND_SCROLL;
            res_o.cnt  = lines;
            res_o.last = 1'b1;
          end
        end
        utf8tc_pkg::OP_RETURN: begin
          op_pop_o = 1'b1;
          col_d    = '0;
        end
        utf8tc_pkg::OP_BACKSPACE: begin
          op_pop_o = 1'b1;
          if (col_q != '0) begin
            col_d = col_q - CCW'(1);
          end else if (row_q != '0) begin
            row_d = row_q - ROW_W'(1);
            col_d = cfg_i.cols - CCW'(1);
          end
          res_push_o  = 1'b1;
          res_o.row   = row_d;
          res_o.col   = col_d[utf8tc_pkg::COL_W-1:0];
          res_o.cp    = utf8tc_pkg::SPACE_CP;
          res_o.color = cfg_i.color;
          res_o.last  = 1'b1;
        end
        utf8tc_pkg::OP_PUT, utf8tc_pkg::OP_TAB: begin
          res_push_o = 1'b1;
          if (wrap && scroll_hit) begin
            // The wrap scrolls first; the operation stays queued and writes its cell after.
            res_o.kind = utf8tc_pkg::KIND_SCROLL;
            res_o.cnt  = lines;
            row_d      = row_scrolled;
            col_d      = '0;
          end else begin
            res_o.row   = wr_row;
            res_o.col   = wr_col[utf8tc_pkg::COL_W-1:0];
            res_o.cp    = (op_i.op == utf8tc_pkg::OP_PUT) ? op_i.cp : utf8tc_pkg::SPACE_CP;
            res_o.color = cfg_i.color;
            res_o.last  = put_done;
            row_d       = wr_row;
            col_d       = wr_col + CCW'(1);
            if (put_done) begin
              op_pop_o = 1'b1;
              step_d   = '0;
            end else begin
              step_d = step_q + TCW'(1);
            end
          end
        end
        default: begin
          op_pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      step_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      step_q <= step_d;
    end
  end

endmodule

>>> design/utf8_text_cursor_engine.sv
// Top level of the UTF-8 text cursor engine: configuration registers,
// decoder front end, operation queue, cursor back end and result queue.
// Depends on utf8tc_pkg, utf8tc_front, utf8tc_fifo and utf8tc_back.
//
//   Channel   Handshake                 Payload
//   input     push, full                in_byte_i
//   result    empty, pop                kind_o .. last_o
//   config    cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// A byte is taken every cycle while the operation queue has room. The back
// end emits at most one result per cycle: a write that wraps and scrolls
// gives a scroll and then its cell, and a tab gives TAB_SPACES cells.
// Reset clears the decoder and cursor and loads the register defaults.
// The back end stalls while the result queue is full; full rises when the
// operation queue is full.
module utf8_text_cursor_engine #(
  parameter int QUEUE_DEPTH = utf8tc_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [utf8tc_pkg::BYTE_W-1:0]       in_byte_i,
  output logic                                empty,
  input  logic                                pop,
  output logic                                kind_o,
  output logic [utf8tc_pkg::ROW_W-1:0]        cell_row_o,
  output logic [utf8tc_pkg::COL_W-1:0]        cell_col_o,
  output logic [utf8tc_pkg::CP_W-1:0]         code_point_o,
  output logic [utf8tc_pkg::COLOR_W-1:0]      glyph_rgb_o,
  output logic [utf8tc_pkg::CNT_W-1:0]        scroll_count_o,
  output logic                                last_o,
  input  logic                                cfg_we_i,
  input  logic [utf8tc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [utf8tc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int OP_W  = $bits(utf8tc_pkg::op_t);
  localparam int RES_W = $bits(utf8tc_pkg::res_t);

  logic [utf8tc_pkg::TCOL_W-1:0]  cols_q;
  logic [utf8tc_pkg::TROW_W-1:0]  rows_q;
  logic [utf8tc_pkg::COLOR_W-1:0] color_q;
  utf8tc_pkg::cfg_t               cfg;

  logic              accept;
  logic              front_valid;
  utf8tc_pkg::op_t   front_op;
  logic [OP_W-1:0]   opq_data;
  utf8tc_pkg::op_t   opq_out;
  logic              opq_empty, opq_pop;
  logic              res_push, res_full;
  utf8tc_pkg::res_t  res_in, res_out;
  logic [RES_W-1:0]  resq_data;
  utf8tc_pkg::stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= utf8tc_pkg::COLUMNS_RESET;
      rows_q  <= utf8tc_pkg::ROWS_RESET;
      color_q <= utf8tc_pkg::COLOR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        utf8tc_pkg::CFG_TEXT_COLUMNS: cols_q  <= cfg_data_i[utf8tc_pkg::TCOL_W-1:0];
        utf8tc_pkg::CFG_TEXT_ROWS:    rows_q  <= cfg_data_i[utf8tc_pkg::TROW_W-1:0];
        utf8tc_pkg::CFG_FORE_COLOR:   color_q <= cfg_data_i[utf8tc_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.color = color_q;
    if (cols_q == '0) begin
      cfg.cols = utf8tc_pkg::TCOL_W'(1);
    end else if (cols_q > utf8tc_pkg::TCOL_W'(utf8tc_pkg::MAX_COLS)) begin
      cfg.cols = utf8tc_pkg::TCOL_W'(utf8tc_pkg::MAX_COLS);
    end else begin
      cfg.cols = cols_q;
    end
    if (rows_q == '0) begin
      cfg.rows = utf8tc_pkg::TROW_W'(1);
    end else if (rows_q > utf8tc_pkg::TROW_W'(utf8tc_pkg::MAX_ROWS)) begin
      cfg.rows = utf8tc_pkg::TROW_W'(utf8tc_pkg::MAX_ROWS);
    end else begin
      cfg.rows = rows_q;
    end
  end

  assign accept = push && !full;

  utf8tc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .op_valid_o (front_valid),
    .op_o       (front_op)
  );

  utf8tc_fifo #(
    .WIDTH (OP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_op),
    .full_o  (full),
    .pop_i   (opq_pop),
    .empty_o (opq_empty),
    .data_o  (opq_data)
  );

  assign opq_out = utf8tc_pkg::op_t'(opq_data);

  utf8tc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .op_valid_i (!opq_empty),
    .op_i       (opq_out),
    .op_pop_o   (opq_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in),
    .stat_o     (stat)
  );

  utf8tc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (resq_data)
  );

  assign res_out        = utf8tc_pkg::res_t'(resq_data);
  assign kind_o         = res_out.kind;
  assign cell_row_o     = res_out.row;
  assign cell_col_o     = res_out.col;
  assign code_point_o   = res_out.cp;
  assign glyph_rgb_o    = res_out.color;
  assign scroll_count_o = res_out.cnt;
  assign last_o         = res_out.last;

  // The back end never offers a result the result queue cannot take.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  // Every scroll leaves the cursor at the start of a row.
  a_scroll_homes_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && (res_in.kind == utf8tc_pkg::KIND_SCROLL)) |=> (stat.col == '0))
    else $error("cursor column not zero after a scroll");

  // Only a tab writes several cells for one request.
  a_multi_cell_is_tab: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && (res_in.kind == utf8tc_pkg::KIND_CELL) && !res_in.last)
      |-> (opq_out.op == utf8tc_pkg::OP_TAB))
    else $error("non-final cell write outside a tab");

endmodule

>>> sim/utf8tc_checker.sv
// Checker for the UTF-8 text cursor engine: watches the byte, result and
// register ports, predicts the cell writes and scrolls and compares them.
// Depends on utf8tc_pkg for widths, codes and the result layout.
module utf8tc_checker
  import utf8tc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  input  logic                  full,
  input  logic [BYTE_W-1:0]     in_byte_i,
  input  logic                  empty,
  input  logic                  pop,
  input  logic                  kind_o,
  input  logic [ROW_W-1:0]      cell_row_o,
  input  logic [COL_W-1:0]      cell_col_o,
  input  logic [CP_W-1:0]       code_point_o,
  input  logic [COLOR_W-1:0]    glyph_rgb_o,
  input  logic [CNT_W-1:0]      scroll_count_o,
  input  logic                  last_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    open_count_o
);

  localparam int BURST_CAP = 8;

  logic [TCOL_W-1:0]  screen_cols;
  logic [TROW_W-1:0]  screen_rows;
  logic [COLOR_W-1:0] ink;
  logic [CP_W-1:0]    partial_cp;
  logic [1:0]         cont_left;
  int                 cur_row;
  int                 cur_col;
  int                 fails;
  res_t               cells_due[$];
  res_t               byte_results[$];

  function automatic int cols_in_use();
    if (screen_cols == 0) return 1;
    if (screen_cols > MAX_COLS) return MAX_COLS;
    return int'(screen_cols);
  endfunction

  function automatic int rows_in_use();
    if (screen_rows == 0) return 1;
    if (screen_rows > MAX_ROWS) return MAX_ROWS;
    return int'(screen_rows);
  endfunction

  function automatic void add_result(kind_e kind, int row, int col, logic [CP_W-1:0] cp,
                                     logic [COLOR_W-1:0] color, int lines);
    res_t r;
    if (byte_results.size() >= BURST_CAP) return;
    r.kind  = kind;
    r.row   = ROW_W'(row);
    r.col   = COL_W'(col);
    r.cp    = cp;
    r.color = color;
    r.cnt   = CNT_W'(lines);
    r.last  = 1'b0;
    byte_results.push_back(r);
  endfunction

  function automatic void write_cell(logic [CP_W-1:0] cp);
    if (cur_row < MAX_ROWS && cur_col < MAX_COLS)
      add_result(KIND_CELL, cur_row, cur_col, cp, ink, 0);
  endfunction

  function automatic void line_feed();
    int lines;
    cur_col = 0;
    cur_row++;
    if (cur_row >= rows_in_use()) begin
      lines = (SCROLL_STEP > rows_in_use()) ? rows_in_use() : SCROLL_STEP;
      add_result(KIND_SCROLL, 0, 0, '0, '0, lines);
      cur_row = (cur_row >= SCROLL_STEP) ? cur_row - SCROLL_STEP : 0;
    end
  endfunction

  function automatic void put_glyph(logic [CP_W-1:0] cp);
    if (cur_col >= cols_in_use()) line_feed();
    write_cell(cp);
    cur_col++;
  endfunction

  // A byte that breaks an unfinished sequence drops it and is then taken
  // as if no sequence had been open.
  function automatic void decode_byte(logic [BYTE_W-1:0] b);
    byte_results.delete();
    if (cont_left != 0 && b[7:6] == 2'b10) begin
      partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
      cont_left--;
      if (cont_left == 0) put_glyph(partial_cp);
    end else begin
      cont_left = 0;
      if (b >= LEAD4_MIN) begin
        partial_cp = CP_W'(b[2:0]);
        cont_left  = 2'd3;
      end else if (b >= LEAD3_MIN) begin
        partial_cp = CP_W'(b[3:0]);
        cont_left  = 2'd2;
      end else if (b >= LEAD2_MIN) begin
        partial_cp = CP_W'(b[4:0]);
        cont_left  = 2'd1;
      end else if (b == BYTE_NEWLINE) begin
        line_feed();
      end else if (b == BYTE_RETURN) begin
        cur_col = 0;
      end else if (b == BYTE_TAB) begin
        for (int k = 0; k < TAB_SPACES; k++) put_glyph(SPACE_CP);
      end else if (b == BYTE_BACKSPACE) begin
        if (cur_col > 0) begin
          cur_col--;
        end else if (cur_row > 0) begin
          cur_row--;
          cur_col = cols_in_use() - 1;
        end
        write_cell(SPACE_CP);
      end else begin
        put_glyph(CP_W'(b));
      end
    end
    if (byte_results.size() > 0) byte_results[$].last = 1'b1;
    foreach (byte_results[k]) cells_due.push_back(byte_results[k]);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fails++;
      $display("%0t checker: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      screen_cols = COLUMNS_RESET;
      screen_rows = ROWS_RESET;
      ink         = COLOR_RESET;
      partial_cp  = '0;
      cont_left   = '0;
      cur_row     = 0;
      cur_col     = 0;
      fails       = 0;
      cells_due.delete();
      open_count_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TEXT_COLUMNS: screen_cols = cfg_data_i[TCOL_W-1:0];
          CFG_TEXT_ROWS:    screen_rows = cfg_data_i[TROW_W-1:0];
          CFG_FORE_COLOR:   ink         = cfg_data_i[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) decode_byte(in_byte_i);
      if (pop && !empty) begin
        if (cells_due.size() == 0) begin
          fails++;
          $display("%0t checker: result with no request pending, kind %0h row %0h col %0h cp %0h",
                   $time, kind_o, cell_row_o, cell_col_o, code_point_o);
        end else begin
          want = cells_due.pop_front();
          check_field("kind", want.kind, kind_o);
          check_field("cell_row", want.row, cell_row_o);
          check_field("cell_col", want.col, cell_col_o);
          check_field("code_point", want.cp, code_point_o);
          check_field("glyph_rgb", want.color, glyph_rgb_o);
          check_field("scroll_count", want.cnt, scroll_count_o);
          check_field("last", want.last, last_o);
        end
      end
      open_count_o <= cells_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

>>> sim/utf8_text_cursor_engine_tb.sv
// Testbench top for the UTF-8 text cursor engine: clock, reset, console
// byte stimulus with random gaps, result pops and screen register settings.
// Depends on utf8tc_pkg, the engine RTL and utf8tc_checker.
module utf8_text_cursor_engine_tb;
  import utf8tc_pkg::*;

  localparam int PHASE_ITEMS   = 22;
  localparam int SETTLE_CYCLES = 16;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  push      = 1'b0;
  logic [BYTE_W-1:0]     text_byte = '0;
  logic                  pop       = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                  full;
  logic                  empty;
  logic                  kind;
  logic [ROW_W-1:0]      cell_row;
  logic [COL_W-1:0]      cell_col;
  logic [CP_W-1:0]       code_point;
  logic [COLOR_W-1:0]    glyph_rgb;
  logic [CNT_W-1:0]      scroll_count;
  logic                  last;
  int                    fail_count;
  int                    open_count;

  bit                    steady = 1'b0;
  int                    bytes_sent = 0;
  logic [BYTE_W-1:0]     script[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  utf8_text_cursor_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .in_byte_i      (text_byte),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind),
    .cell_row_o     (cell_row),
    .cell_col_o     (cell_col),
    .code_point_o   (code_point),
    .glyph_rgb_o    (glyph_rgb),
    .scroll_count_o (scroll_count),
    .last_o         (last),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  utf8tc_checker u_watch (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .in_byte_i      (text_byte),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind),
    .cell_row_o     (cell_row),
    .cell_col_o     (cell_col),
    .code_point_o   (code_point),
    .glyph_rgb_o    (glyph_rgb),
    .scroll_count_o (scroll_count),
    .last_o         (last),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .open_count_o   (open_count)
  );

  function automatic int idle_cycles();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    text_byte <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_script();
    foreach (script[k]) send_byte(script[k]);
  endtask

  // Lets every expected result arrive, then gives result-less requests
  // still in flight time to retire before the registers change.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (open_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_screen(input int unsigned cols, input int unsigned rows,
                                input int unsigned color);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TEXT_COLUMNS;
    cfg_data  <= CFG_DATA_W'(cols);
    @(posedge clk_i);
    cfg_index <= CFG_TEXT_ROWS;
    cfg_data  <= CFG_DATA_W'(rows);
    @(posedge clk_i);
    cfg_index <= CFG_FORE_COLOR;
    cfg_data  <= CFG_DATA_W'(color);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed sequences with random payload, some broken ones,
  // control bytes and raw noise.
  task automatic send_unit();
    int pick;
    int len;
    int cut;
    logic [BYTE_W-1:0] lead;
    logic [BYTE_W-1:0] breaker;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_byte(BYTE_W'($urandom_range(8'h20, 8'h7E)));
    end else if (pick < 42) begin
      case ($urandom_range(0, 4))
        0:       send_byte(BYTE_NEWLINE);
        1:       send_byte(BYTE_RETURN);
        2:       send_byte(BYTE_TAB);
        3:       send_byte(BYTE_BACKSPACE);
        default: send_byte(BYTE_W'($urandom_range(0, 8'h1F)));
      endcase
    end else if (pick < 90) begin
      len = $urandom_range(2, 4);
      case (len)
        2:       lead = {3'b110, 5'($urandom)};
        3:       lead = {4'b1110, 4'($urandom)};
        default: lead = {4'b1111, 4'($urandom)};
      endcase
      cut = (pick < 78) ? len : $urandom_range(1, len - 1);
      send_byte(lead);
      for (int k = 1; k < cut; k++) send_byte({2'b10, 6'($urandom)});
      if (cut < len) begin
        breaker = 8'($urandom);
        if (breaker[7:6] == 2'b10) breaker[6] = 1'b1;
        send_byte(breaker);
      end
    end else begin
      send_byte(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = idle_cycles();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin
    int target;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    script = '{BYTE_BACKSPACE, 8'h00, 8'h7F, 8'h41, 8'h80, 8'hBF,
               8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
               8'hFF, 8'h80, 8'h80, 8'h80, 8'hC3, 8'h41, 8'hE2, BYTE_NEWLINE,
               BYTE_BACKSPACE, BYTE_TAB, BYTE_RETURN};
    send_script();
    drain();

    program_screen(1, 1, 0);
    script = '{8'h41, 8'h42, BYTE_TAB, BYTE_BACKSPACE, BYTE_BACKSPACE,
               BYTE_NEWLINE, 8'hF0, 8'h90, 8'h80, 8'h80, BYTE_RETURN, 8'h43};
    send_script();
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      steady = (phase == 2);
      case (phase)
        0: program_screen(MAX_COLS, MAX_ROWS, 24'hFFFFFF);
        1: program_screen(0, 0, $urandom_range(0, 24'hFFFFFF));
        2: program_screen(511, 255, $urandom_range(0, 24'hFFFFFF));
        3: program_screen($urandom_range(1, 12), $urandom_range(1, 10),
                          $urandom_range(0, 24'hFFFFFF));
        default: program_screen($urandom_range(0, 511), $urandom_range(0, 255),
                                $urandom_range(0, 24'hFFFFFF));
      endcase
      target = bytes_sent + PHASE_ITEMS;
      while (bytes_sent < target) send_unit();
      drain();
    end

    if (fail_count == 0 && open_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
